>>> design/erst_pkg.sv
// shared types and constants for the elevation error statistics block
package erst_pkg;

   // fixed widths of the register file and result words
   localparam int GRID_BITS      = 25;
   localparam int SQ_BITS        = 64;
   localparam int ROOT_BITS      = 32;
   localparam int ALU_BITS       = 36;
   localparam int STEP_BITS      = 7;
   localparam int CSR_INDEX_BITS = 1;

   // running max starts low and running min starts high
   localparam int RESET_MAX = -10000000;
   localparam int RESET_MIN = 10000000;
   localparam int EXTREME_BITS = 25;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NO_DATA     = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_POINTS = 1'd1;

   // accumulator controls from the sequencer
   typedef struct packed {
      logic step;
      logic clear;
   } acc_ctl_type;

endpackage

>>> design/erst_if.sv
// word channels: sample pairs in, statistics out
interface erst_req_if #(
   parameter int HEIGHT_BITS = 24
);
   logic                   valid;
   logic                   ready;
   logic [HEIGHT_BITS-1:0] reference_height;
   logic [HEIGHT_BITS-1:0] compared_height;
   logic                   final_point;

   modport source (output valid, reference_height, compared_height, final_point,
                   input ready);
   modport sink   (input valid, reference_height, compared_height, final_point,
                   output ready);
endinterface

interface erst_rsp_if #(
   parameter int HEIGHT_BITS = 24
);
   logic                        valid;
   logic                        ready;
   logic [HEIGHT_BITS:0]        largest_difference;
   logic [HEIGHT_BITS:0]        smallest_difference;
   logic [HEIGHT_BITS:0]        mean_difference;
   logic [erst_pkg::ROOT_BITS-1:0] rms_difference;

   modport source (output valid, largest_difference, smallest_difference,
                   mean_difference, rms_difference, input ready);
   modport sink   (input valid, largest_difference, smallest_difference,
                   mean_difference, rms_difference, output ready);
endinterface

>>> design/erst_accum.sv
// difference, extremes, sum and saturating sum of squares over valid pairs
module erst_accum #(
   parameter int HEIGHT_BITS = 24,
   parameter int COUNT_BITS  = 24
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  erst_pkg::acc_ctl_type                        ctl,
   input  logic [HEIGHT_BITS-1:0]                       reference_height,
   input  logic [HEIGHT_BITS-1:0]                       compared_height,
   input  logic [HEIGHT_BITS-1:0]                       no_data_value,
   output logic [HEIGHT_BITS:0]                         running_max,
   output logic [HEIGHT_BITS:0]                         running_min,
   output logic [HEIGHT_BITS+COUNT_BITS:0]              difference_sum,
   output logic [erst_pkg::SQ_BITS-1:0]                 squared_sum,
   output logic                                         done
);
   localparam int DIFF_BITS = HEIGHT_BITS + 1;
   localparam int SUM_BITS  = HEIGHT_BITS + COUNT_BITS + 1;
   localparam int EXT_BITS  = (DIFF_BITS > erst_pkg::EXTREME_BITS) ? DIFF_BITS
                                                                   : erst_pkg::EXTREME_BITS;
   localparam int SQ_BITS   = erst_pkg::SQ_BITS;
   localparam logic signed [EXT_BITS-1:0] MAX_INIT = EXT_BITS'(erst_pkg::RESET_MAX);
   localparam logic signed [EXT_BITS-1:0] MIN_INIT = EXT_BITS'(erst_pkg::RESET_MIN);

   logic                          s1_ff, s1_in, s2_ff, s2_in;
   logic                          use_ff, use_in;
   logic [DIFF_BITS-1:0]          diff_ff, diff_in;
   logic [2*HEIGHT_BITS-1:0]      prod_ff, prod_in;
   logic signed [EXT_BITS-1:0]    max_ff, max_in, min_ff, min_in;
   logic [SUM_BITS-1:0]           sum_ff, sum_in;
   logic [SQ_BITS-1:0]            sq_ff, sq_in;
   logic signed [EXT_BITS-1:0]    diff_ext;
   logic [DIFF_BITS-1:0]          diff_abs;
   logic [SQ_BITS:0]              sq_next;

   // stage 0: difference and no-data check on the accepted word
   always_comb begin
      use_in  = use_ff;
      diff_in = diff_ff;
      s1_in   = ctl.step;
      if (ctl.step) begin
         use_in  = (reference_height != no_data_value) &&
                   (compared_height != no_data_value);
         diff_in = {compared_height[HEIGHT_BITS-1], compared_height} -
                   {reference_height[HEIGHT_BITS-1], reference_height};
      end
   end

   // stage 1: extremes, sum and square
   assign diff_ext = EXT_BITS'(signed'(diff_ff));
   assign diff_abs = diff_ff[DIFF_BITS-1] ? (~diff_ff + 1'b1) : diff_ff;
   assign prod_in  = diff_abs[HEIGHT_BITS-1:0] * diff_abs[HEIGHT_BITS-1:0];
   assign s2_in    = s1_ff;

   // stage 2: saturating add of the square
   assign sq_next = {1'b0, sq_ff} + (SQ_BITS+1)'(prod_ff);

   always_comb begin
      max_in = max_ff;
      min_in = min_ff;
      sum_in = sum_ff;
      sq_in  = sq_ff;
      if (ctl.clear) begin
         max_in = MAX_INIT;
         min_in = MIN_INIT;
         sum_in = '0;
         sq_in  = '0;
      end else begin
         if (s1_ff && use_ff) begin
            if (diff_ext > max_ff) max_in = diff_ext;
            if (diff_ext < min_ff) min_in = diff_ext;
            sum_in = sum_ff + SUM_BITS'(signed'(diff_ff));
         end
         if (s2_ff && use_ff) begin
            sq_in = sq_next[SQ_BITS] ? '1 : sq_next[SQ_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff  <= 1'b0;
         s2_ff  <= 1'b0;
         max_ff <= MAX_INIT;
         min_ff <= MIN_INIT;
         sum_ff <= '0;
         sq_ff  <= '0;
      end else begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         max_ff <= max_in;
         min_ff <= min_in;
         sum_ff <= sum_in;
         sq_ff  <= sq_in;
      end
   end

   always_ff @(posedge clock) begin
      use_ff  <= use_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
   end

   assign running_max    = max_ff[DIFF_BITS-1:0];
   assign running_min    = min_ff[DIFF_BITS-1:0];
   assign difference_sum = sum_ff;
   assign squared_sum    = sq_ff;
   assign done           = s2_ff;
endmodule

>>> design/erst_divsqrt.sv
// mean and rms by restoring division and square root on one shared subtractor
module erst_divsqrt #(
   parameter int HEIGHT_BITS = 24,
   parameter int COUNT_BITS  = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [HEIGHT_BITS+COUNT_BITS:0]       difference_sum,
   input  logic [erst_pkg::SQ_BITS-1:0]          squared_sum,
   input  logic [erst_pkg::GRID_BITS-1:0]        grid_points,
   output logic [HEIGHT_BITS:0]                  mean_difference,
   output logic [erst_pkg::ROOT_BITS-1:0]        rms_difference,
   output logic                                  done
);
   localparam int DIFF_BITS = HEIGHT_BITS + 1;
   localparam int SUM_BITS  = HEIGHT_BITS + COUNT_BITS + 1;
   localparam int SQ_BITS   = erst_pkg::SQ_BITS;
   localparam int ALU_BITS  = erst_pkg::ALU_BITS;
   localparam int ROOT_BITS = erst_pkg::ROOT_BITS;
   localparam int STEP_BITS = erst_pkg::STEP_BITS;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MEAN  = 2'd1;
   localparam logic [1:0] ST_SQDIV = 2'd2;
   localparam logic [1:0] ST_SQRT  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [STEP_BITS-1:0]   count_ff, count_in;
   logic [ALU_BITS-1:0]    rem_ff, rem_in;
   logic [SQ_BITS-1:0]     dvd_ff, dvd_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic                   neg_ff, neg_in, zero_ff, zero_in, done_ff, done_in;
   logic [DIFF_BITS-1:0]   mean_ff, mean_in;

   logic [ALU_BITS-1:0]    alu_a, alu_b, alu_diff;
   logic [ALU_BITS:0]      alu_full;
   logic                   alu_ge;
   logic [SUM_BITS-1:0]    sum_mag, quo;
   logic                   quo_sat;
   logic [DIFF_BITS-1:0]   quo_mag;

   // shared subtract and compare
   always_comb begin
      if (state_ff == ST_SQRT) begin
         alu_a = {rem_ff[ALU_BITS-3:0], dvd_ff[SQ_BITS-1 -: 2]};
         alu_b = ALU_BITS'({root_ff, 2'b01});
      end else begin
         alu_a = {rem_ff[ALU_BITS-2:0], dvd_ff[SQ_BITS-1]};
         alu_b = ALU_BITS'(grid_points);
      end
   end
   assign alu_full = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_ge   = ~alu_full[ALU_BITS];
   assign alu_diff = alu_full[ALU_BITS-1:0];

   // sum magnitude and saturated signed mean
   assign sum_mag = difference_sum[SUM_BITS-1] ? (~difference_sum + 1'b1) : difference_sum;
   assign quo     = dvd_ff[SUM_BITS-1:0];
   assign quo_sat = |quo[SUM_BITS-1:HEIGHT_BITS];
   assign quo_mag = quo_sat ? {1'b0, {HEIGHT_BITS{1'b1}}} : {1'b0, quo[HEIGHT_BITS-1:0]};

   // sequencer: mean division, squared division, then square root
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      root_in  = root_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      mean_in  = mean_ff;
      done_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in   = difference_sum[SUM_BITS-1];
               zero_in  = (grid_points == '0);
               dvd_in   = SQ_BITS'(sum_mag) << (SQ_BITS - SUM_BITS);
               rem_in   = '0;
               count_in = STEP_BITS'(SUM_BITS);
               state_in = ST_MEAN;
            end
         end
         ST_MEAN, ST_SQDIV: begin
            if (count_ff != '0) begin
               rem_in   = alu_ge ? alu_diff : alu_a;
               dvd_in   = {dvd_ff[SQ_BITS-2:0], alu_ge};
               count_in = count_ff - 1'b1;
            end else if (state_ff == ST_MEAN) begin
               if (zero_ff)     mean_in = '0;
               else if (neg_ff) mean_in = ~quo_mag + 1'b1;
               else             mean_in = quo_mag;
               dvd_in   = squared_sum;
               rem_in   = '0;
               count_in = STEP_BITS'(SQ_BITS);
               state_in = ST_SQDIV;
            end else begin
               rem_in   = '0;
               root_in  = '0;
               count_in = STEP_BITS'(ROOT_BITS);
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (count_ff != '0) begin
               rem_in   = alu_ge ? alu_diff : alu_a;
               root_in  = {root_ff[ROOT_BITS-2:0], alu_ge};
               dvd_in   = {dvd_ff[SQ_BITS-3:0], 2'b00};
               count_in = count_ff - 1'b1;
            end else begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      root_ff <= root_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      mean_ff <= mean_in;
   end

   assign mean_difference = mean_ff;
   assign rms_difference  = zero_ff ? '0 : root_ff;
   assign done            = done_ff;
endmodule

>>> design/elevation_error_statistics.sv
// top level: elevation error statistics over a stream of sample pairs
//
//   channel | direction | carries
//   req     | in        | reference and compared height, final point flag
//   rsp     | out       | largest, smallest and mean difference, rms
//   csr     | in        | no-data value (index 0), grid points (index 1)
//
// a non-final word is accepted with its difference, then passes two accumulate stages
// (extremes, sum and square, then saturating add of the square)
// a final word then runs the shared subtractor through mean division, squared-sum
// division and a 32-step square root
// the result sits in an output register; new words are taken while it waits, but a
// further final word holds in its load step until that register drains
// synchronous reset restores the control state, configuration and accumulators; the result registers are not reset
module elevation_error_statistics #(
   parameter int HEIGHT_BITS = 24,
   parameter int COUNT_BITS  = 24
) (
   input  logic                                     clock,
   input  logic                                     reset,
   erst_req_if.sink                                 req,
   erst_rsp_if.source                               rsp,
   input  logic                                     csr_write_enable,
   input  logic [erst_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [((HEIGHT_BITS > erst_pkg::GRID_BITS) ? HEIGHT_BITS
                                                      : erst_pkg::GRID_BITS)-1:0]
                                                    csr_write_data
);
   localparam int DIFF_BITS = HEIGHT_BITS + 1;
   localparam int SUM_BITS  = HEIGHT_BITS + COUNT_BITS + 1;
   localparam int GRID_BITS = erst_pkg::GRID_BITS;
   localparam int ROOT_BITS = erst_pkg::ROOT_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ACC  = 3'd1;
   localparam logic [2:0] ST_GO   = 3'd2;
   localparam logic [2:0] ST_CALC = 3'd3;
   localparam logic [2:0] ST_LOAD = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic                       last_ff, last_in;
   logic [HEIGHT_BITS-1:0]     no_data_ff, no_data_in;
   logic [GRID_BITS-1:0]       grid_ff, grid_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [DIFF_BITS-1:0]       max_out_ff, min_out_ff, mean_out_ff;
   logic [ROOT_BITS-1:0]       rms_out_ff;

   erst_pkg::acc_ctl_type      acc_ctl;
   logic                       acc_done, calc_start, calc_done, accept, load;
   logic [DIFF_BITS-1:0]       acc_max, acc_min, calc_mean;
   logic [SUM_BITS-1:0]        acc_sum;
   logic [erst_pkg::SQ_BITS-1:0] acc_sq;
   logic [ROOT_BITS-1:0]       calc_rms;

   // configuration registers
   always_comb begin
      no_data_in = no_data_ff;
      grid_in    = grid_ff;
      if (csr_write_enable) begin
         case (csr_index)
            erst_pkg::CSR_NO_DATA:     no_data_in = csr_write_data[HEIGHT_BITS-1:0];
            erst_pkg::CSR_GRID_POINTS: grid_in    = csr_write_data[GRID_BITS-1:0];
            default: begin
               no_data_in = no_data_ff;
            end
         endcase
      end
   end

   // sequencer
   assign req.ready  = (state_ff == ST_IDLE);
   assign accept     = req.valid && req.ready;
   assign load       = (state_ff == ST_LOAD) && (!rsp_valid_ff || rsp.ready);
   assign calc_start = (state_ff == ST_GO);
   assign acc_ctl    = '{step: accept, clear: load};

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in  = req.final_point;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (acc_done) state_in = last_ff ? ST_GO : ST_IDLE;
         end
         ST_GO: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (calc_done) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (load) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load)           rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= 1'b0;
         no_data_ff   <= {1'b1, {(HEIGHT_BITS-1){1'b0}}};
         grid_ff      <= GRID_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         no_data_ff   <= no_data_in;
         grid_ff      <= grid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         max_out_ff  <= acc_max;
         min_out_ff  <= acc_min;
         mean_out_ff <= calc_mean;
         rms_out_ff  <= calc_rms;
      end
   end

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.largest_difference  = max_out_ff;
   assign rsp.smallest_difference = min_out_ff;
   assign rsp.mean_difference     = mean_out_ff;
   assign rsp.rms_difference      = rms_out_ff;

   erst_accum #(
      .HEIGHT_BITS (HEIGHT_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_accum (
      .clock            (clock),
      .reset            (reset),
      .ctl              (acc_ctl),
      .reference_height (req.reference_height),
      .compared_height  (req.compared_height),
      .no_data_value    (no_data_ff),
      .running_max      (acc_max),
      .running_min      (acc_min),
      .difference_sum   (acc_sum),
      .squared_sum      (acc_sq),
      .done             (acc_done)
   );

   erst_divsqrt #(
      .HEIGHT_BITS (HEIGHT_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_divsqrt (
      .clock           (clock),
      .reset           (reset),
      .start           (calc_start),
      .difference_sum  (acc_sum),
      .squared_sum     (acc_sq),
      .grid_points     (grid_ff),
      .mean_difference (calc_mean),
      .rms_difference  (calc_rms),
      .done            (calc_done)
   );
endmodule
